/* rtl/rmt_pkg.sv */
package rmt_pkg;

   localparam int VALUE_W = 31;
   localparam int POS_W   = 10;

   typedef logic [VALUE_W-1:0] value_type;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

endpackage

/* rtl/rmt_node_ram.sv */
module rmt_node_ram import rmt_pkg::*; #(
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  value_type         wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output value_type         rd_a_data,
   output value_type         rd_b_data
);

   value_type mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read ports, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

/* rtl/range_max_tree.sv */
// range maximum tree over LEAF_COUNT 31-bit leaves, all zero after reset
// input channel: start with req_* fields, taken at an edge where busy is low
//   req_func write: leaf req_position gets req_value if that leaf exists, no result
//   req_func query: max over req_range_low..req_range_high, clipped to the
//   leaves that exist, 0 when the range is empty
// result channel: rsp_valid is high for one cycle with rsp_max_value; the
//   receiver cannot stall, so a result is never held back
// write: a walk from the leaf up to the root with busy high; the sibling read
//   of one level overlaps the parent write of the level below
// query: one tree level per cycle using the two read ports of the node ram; the
//   result shows in the first cycle with busy low;
//   an empty range answers in the cycle after acceptance
// one transaction at a time: busy stays high until the tree walk ends
// reset: a clearing pass writes zero to all 2*P node slots (P = LEAF_COUNT
//   rounded up to a power of two), one per cycle, with busy high
module range_max_tree import rmt_pkg::*; #(
   parameter int LEAF_COUNT = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_func,
   input  logic [POS_W-1:0] req_position,
   input  value_type        req_value,
   input  logic [POS_W-1:0] req_range_low,
   input  logic [POS_W-1:0] req_range_high,
   output logic             rsp_valid,
   output value_type        rsp_max_value
);

   // tree levels, node address width (heap order, root at 1), walk bound width
   localparam int LW = $clog2(LEAF_COUNT);
   localparam int NW = LW + 1;
   localparam int SW = LW + 2;
   localparam int CW = (LW > POS_W) ? LW : POS_W;
   localparam logic [CW-1:0] LAST_LEAF = CW'(LEAF_COUNT - 1);
   localparam logic [NW-1:0] LAST_NODE = {NW{1'b1}};
   localparam logic [NW-1:0] ROOT_NODE = NW'(1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_QUERY
   } state_type;

   state_type        state_ff;
   logic [NW-1:0]    clr_ff;
   logic [NW-1:0]    node_ff;
   value_type        cur_ff;
   logic [SW-1:0]    lo_ff;
   logic [SW-1:0]    hi_ff;
   logic             hit_a_ff;
   logic             hit_b_ff;
   value_type        acc_ff;
   logic             rsp_valid_ff;
   value_type        rsp_max_ff;

   logic             accept;
   logic             rsp_valid_in;
   logic [CW-1:0]    pos_ext;
   logic [CW-1:0]    lo_ext;
   logic [CW-1:0]    hi_ext;
   logic [CW-1:0]    hi_clip;
   logic             pos_ok;
   logic             q_empty;
   logic [NW-1:0]    leaf_addr;
   logic [SW-1:0]    l_start;
   logic [SW-1:0]    r_start;
   logic [NW-1:0]    parent;
   logic             q_more;
   value_type        rd_a_data;
   value_type        rd_b_data;
   value_type        new_max;
   value_type        part_a;
   value_type        part_b;
   value_type        merge_a;
   value_type        merged;
   logic             wr_en;
   logic [NW-1:0]    wr_addr;
   value_type        wr_data;
   logic [NW-1:0]    rd_a_addr;
   logic [NW-1:0]    rd_b_addr;

   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start & ~busy;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_max_ff;

   // request decode: range check of the leaf, clipping of the query range
   assign pos_ext   = CW'(req_position);
   assign lo_ext    = CW'(req_range_low);
   assign hi_ext    = CW'(req_range_high);
   assign pos_ok    = (pos_ext <= LAST_LEAF);
   assign hi_clip   = (hi_ext > LAST_LEAF) ? LAST_LEAF : hi_ext;
   assign q_empty   = (lo_ext > hi_clip);
   assign leaf_addr = {1'b1, pos_ext[LW-1:0]};
   // half-open node bounds [l, r) on the leaf row
   assign l_start   = {2'b01, lo_ext[LW-1:0]};
   assign r_start   = {2'b01, hi_clip[LW-1:0]} + SW'(1);

   // write walk: parent of the node written last cycle
   assign parent  = {1'b0, node_ff[NW-1:1]};
   assign new_max = (rd_a_data > cur_ff) ? rd_a_data : cur_ff;

   // query walk: fold in the nodes whose reads landed this cycle
   assign q_more  = (lo_ff < hi_ff);
   assign part_a  = hit_a_ff ? rd_a_data : '0;
   assign part_b  = hit_b_ff ? rd_b_data : '0;
   assign merge_a = (part_a > acc_ff) ? part_a : acc_ff;
   assign merged  = (part_b > merge_a) ? part_b : merge_a;

   // a result goes out for an empty query at once, or when the walk ends
   assign rsp_valid_in = (accept && (req_func == FUNC_QUERY) && q_empty) ||
                         ((state_ff == ST_QUERY) && !q_more);

   // node ram port selection
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = clr_ff;
      wr_data   = '0;
      rd_a_addr = lo_ff[NW-1:0];
      rd_b_addr = NW'(hi_ff - SW'(1));
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            // leaf write and the read of its sibling go out together
            wr_en     = accept && (req_func == FUNC_WRITE) && pos_ok;
            wr_addr   = leaf_addr;
            wr_data   = req_value;
            rd_a_addr = leaf_addr ^ NW'(1);
         end
         ST_WRITE: begin
            wr_en     = 1'b1;
            wr_addr   = parent;
            wr_data   = new_max;
            rd_a_addr = parent ^ NW'(1);
         end
         ST_QUERY: begin
         end
         default: begin
         end
      endcase
   end

   rmt_node_ram #(
      .ADDR_W (NW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hit_a_ff     <= 1'b0;
         hit_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + NW'(1);
               if (clr_ff == LAST_NODE) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (req_func == FUNC_WRITE) begin
                     node_ff <= leaf_addr;
                     cur_ff  <= req_value;
                     // a write past the last leaf is dropped
                     if (pos_ok) begin
                        state_ff <= ST_WRITE;
                     end
                  end else if (q_empty) begin
                     rsp_max_ff <= '0;
                  end else begin
                     lo_ff    <= l_start;
                     hi_ff    <= r_start;
                     acc_ff   <= '0;
                     hit_a_ff <= 1'b0;
                     hit_b_ff <= 1'b0;
                     state_ff <= ST_QUERY;
                  end
               end
            end
            ST_WRITE: begin
               node_ff <= parent;
               cur_ff  <= new_max;
               if (parent == ROOT_NODE) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_QUERY: begin
               acc_ff <= merged;
               if (q_more) begin
                  // odd left bound and odd right bound stand outside their parents
                  hit_a_ff <= lo_ff[0];
                  hit_b_ff <= hi_ff[0];
                  lo_ff    <= (lo_ff + SW'(lo_ff[0])) >> 1;
                  hi_ff    <= hi_ff >> 1;
               end else begin
                  hit_a_ff   <= 1'b0;
                  hit_b_ff   <= 1'b0;
                  rsp_max_ff <= merged;
                  state_ff   <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/rmt_checker.sv */
module rmt_checker import rmt_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_func,
   input logic rsp_valid
);

   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("no clearing pass after reset");

   // a write transaction never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_WRITE) |=> !rsp_valid)
      else $error("result after a write");

   // a query either walks the tree or answers at once
   a_query_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_QUERY) |=> (busy || rsp_valid))
      else $error("query neither busy nor answered");

   // a result shows only once the walk is over
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

endmodule

bind range_max_tree rmt_checker u_rmt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_func  (req_func),
   .rsp_valid (rsp_valid)
);

/* tb/sv/tb.sv */
module tb import rmt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // block size, matches the default of the dut
   localparam int LEAVES = 1024;
   localparam value_type VALUE_TOP = {VALUE_W{1'b1}};
   localparam int N_DIRECTED = 23;
   localparam int N_RANDOM = 1150;
   // cycles to wait after the last result, longer than one tree walk
   localparam int DRAIN_CYCLES = 30;

   // one row of the directed table; known_max is used when has_known is set
   typedef struct packed {
      func_type         func;
      logic [POS_W-1:0] position;
      value_type        value;
      logic [POS_W-1:0] range_low;
      logic [POS_W-1:0] range_high;
      logic             has_known;
      value_type        known_max;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_func;
   logic [POS_W-1:0] req_position;
   value_type        req_value;
   logic [POS_W-1:0] req_range_low;
   logic [POS_W-1:0] req_range_high;
   logic             rsp_valid;
   value_type        rsp_max_value;

   // predictor state: the leaf values, inner maxima follow from them
   value_type leaf_values [LEAVES];
   // maxima still owed by the dut, oldest first
   value_type pending_maxima [$];
   int        accepted_txns;
   int        error_count;

   // expectation typed in by the directed table for the transaction on the bus
   logic      cur_has_known;
   value_type cur_known_max;

   range_max_tree #(.LEAF_COUNT(LEAVES)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_position   (req_position),
      .req_value      (req_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_valid      (rsp_valid),
      .rsp_max_value  (rsp_max_value)
   );

   // directed part: reset state, extremes, empty ranges, ignored fields,
   // and writes that lower a maximum so the path must be recomputed
   stim_row_type directed_rows [N_DIRECTED] = '{
      // all zero right after the clearing pass
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd0,    10'd1023, 1'b1, 31'd0},
      // empty range, low above high
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd1023, 10'd0,    1'b1, 31'd0},
      // writes carry junk in the range fields, which must be ignored
      '{FUNC_WRITE, 10'd0,    VALUE_TOP,      10'd1023, 10'd1023, 1'b0, 31'd0},
      '{FUNC_WRITE, 10'd1023, 31'd1,          10'd1023, 10'd0,    1'b0, 31'd0},
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd0,    10'd1023, 1'b1, VALUE_TOP},
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd1023, 10'd1023, 1'b1, 31'd1},
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd0,    10'd0,    1'b1, VALUE_TOP},
      // query with junk in position and value
      '{FUNC_QUERY, 10'd1023, VALUE_TOP,      10'd1,    10'd1022, 1'b1, 31'd0},
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd512,  10'd511,  1'b1, 31'd0},
      // lowering the top leaf, root must drop to the other side
      '{FUNC_WRITE, 10'd0,    31'd0,          10'd0,    10'd0,    1'b0, 31'd0},
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd0,    10'd1023, 1'b1, 31'd1},
      '{FUNC_WRITE, 10'd511,  31'h2AAA_AAAA,  10'd0,    10'd0,    1'b0, 31'd0},
      '{FUNC_WRITE, 10'd512,  31'h5555_5555,  10'd0,    10'd0,    1'b0, 31'd0},
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd511,  10'd511,  1'b0, 31'd0},
      // range straddling the root split
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd511,  10'd512,  1'b1, 31'h5555_5555},
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd0,    10'd511,  1'b1, 31'h2AAA_AAAA},
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd513,  10'd1023, 1'b1, 31'd1},
      '{FUNC_WRITE, 10'd512,  31'd0,          10'd3,    10'd2,    1'b0, 31'd0},
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd256,  10'd767,  1'b1, 31'h2AAA_AAAA},
      '{FUNC_WRITE, 10'd1023, 31'd0,          10'd0,    10'd0,    1'b0, 31'd0},
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd0,    10'd1023, 1'b0, 31'd0},
      '{FUNC_WRITE, 10'd700,  31'h1234_5678,  10'd0,    10'd0,    1'b0, 31'd0},
      '{FUNC_QUERY, 10'd0,    31'd0,          10'd600,  10'd800,  1'b0, 31'd0}
   };

   // maximum over the stored leaves in [lo, hi], clipped to the leaf count
   function automatic value_type predict_range_max(logic [POS_W-1:0] lo,
                                                   logic [POS_W-1:0] hi);
      value_type best;
      int        top;
      best = '0;
      top = (int'(hi) > LEAVES - 1) ? LEAVES - 1 : int'(hi);
      for (int i = int'(lo); i <= top; i++) begin
         if (leaf_values[i] > best) best = leaf_values[i];
      end
      return best;
   endfunction

   // present one transaction after a random idle gap, return once accepted
   task automatic send_txn(input func_type func, input logic [POS_W-1:0] position,
                           input value_type value, input logic [POS_W-1:0] lo,
                           input logic [POS_W-1:0] hi, input logic has_known,
                           input value_type known_max, input int idle_pct);
      int prev_count;
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_func       = func;
      req_position   = position;
      req_value      = value;
      req_range_low  = lo;
      req_range_high = hi;
      cur_has_known  = has_known;
      cur_known_max  = known_max;
      prev_count     = accepted_txns;
      start          = 1'b1;
      do @(negedge clock); while (accepted_txns == prev_count);
   endtask

   // clock, 10 ns period
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // monitor: results are checked before a new transaction is taken in the
   // same edge, so the queue order matches the dut order
   always @(posedge clock) begin
      value_type expected;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_maxima.size() == 0) begin
               $error("max_value: no transaction pending, actual %0h", rsp_max_value);
               error_count++;
            end else begin
               expected = pending_maxima.pop_front();
               if (rsp_max_value !== expected) begin
                  $error("max_value: expected %0h, actual %0h", expected, rsp_max_value);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            accepted_txns++;
            if (req_func == FUNC_WRITE) begin
               // a write past the leaf count leaves the tree alone
               if (int'(req_position) < LEAVES) leaf_values[req_position] = req_value;
            end else if (cur_has_known) begin
               pending_maxima.push_back(cur_known_max);
            end else begin
               pending_maxima.push_back(predict_range_max(req_range_low, req_range_high));
            end
         end
      end
   end

   // stimulus
   initial begin
      int        idle_pct;
      int        win_base;
      int        pick;
      func_type  func;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      logic [POS_W-1:0] swap;
      value_type value;

      for (int i = 0; i < LEAVES; i++) leaf_values[i] = '0;
      accepted_txns  = 0;
      error_count    = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = 1'b0;
      req_position   = '0;
      req_value      = '0;
      req_range_low  = '0;
      req_range_high = '0;
      cur_has_known  = 1'b0;
      cur_known_max  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table walk, the dut is still clearing and holds busy
      foreach (directed_rows[i]) begin
         send_txn(directed_rows[i].func, directed_rows[i].position,
                  directed_rows[i].value, directed_rows[i].range_low,
                  directed_rows[i].range_high, directed_rows[i].has_known,
                  directed_rows[i].known_max, 12);
      end

      // random part in three pacing phases: light gaps, heavy gaps, none
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n < N_RANDOM / 3) idle_pct = 12;
         else if (n < 2 * N_RANDOM / 3) idle_pct = 65;
         else idle_pct = 0;
         // writes cluster in a moving window so queries see fresh maxima
         if (n % 64 == 0) win_base = $urandom_range(LEAVES - 32);

         func = ($urandom_range(99) < 45) ? FUNC_WRITE : FUNC_QUERY;

         pick = $urandom_range(99);
         if (pick < 50) position = POS_W'(win_base + $urandom_range(31));
         else if (pick < 55) position = '0;
         else if (pick < 60) position = POS_W'(LEAVES - 1);
         else position = POS_W'($urandom());

         pick = $urandom_range(99);
         if (pick < 12) value = '0;
         else if (pick < 18) value = VALUE_TOP;
         else if (pick < 38) value = value_type'($urandom_range(15));
         else value = value_type'($urandom());

         pick = $urandom_range(99);
         lo = POS_W'($urandom());
         hi = POS_W'($urandom());
         if (pick < 35) begin
            // narrow range over the write window
            lo = POS_W'(win_base + $urandom_range(31));
            hi = POS_W'(int'(lo) + $urandom_range(8));
            if (hi < lo) hi = POS_W'(LEAVES - 1);
         end else if (pick < 43) begin
            lo = '0;
            hi = POS_W'(LEAVES - 1);
         end else if (pick < 53) begin
            // empty range
            if (lo == hi) hi = lo - 1'b1;
            if (lo < hi) begin
               swap = lo;
               lo = hi;
               hi = swap;
            end
            if (lo == 0) begin
               lo = 10'd1;
               hi = 10'd0;
            end
         end else if (pick < 58) begin
            hi = lo;
         end else if (lo > hi) begin
            swap = lo;
            lo = hi;
            hi = swap;
         end

         send_txn(func, position, value, lo, hi, 1'b0, '0, idle_pct);
      end
      start = 1'b0;

      // drain outstanding results, then let the last tree walk settle
      while (pending_maxima.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/rmt_pkg.sv
rtl/rmt_node_ram.sv
rtl/range_max_tree.sv
rtl/rmt_checker.sv
tb/sv/tb.sv
